// ----- hdl/rgbihs_pkg.sv -----
// Shared constants, types and the divider step for the RGB/IHS pixel converter.
// No dependencies; imported by the converter core.
`default_nettype none
package rgbihs_pkg;

  localparam logic [1:0] CFG_BACKWARD = 2'd0;
  localparam logic [1:0] CFG_CLAMP    = 2'd1;
  localparam logic [1:0] CFG_HALF     = 2'd2;

  localparam logic [14:0] FS_BYTE  = 15'd255;
  localparam logic [14:0] FS_HALF  = 15'd32767;
  localparam logic [29:0] FS2_BYTE = 30'd65025;
  localparam logic [29:0] FS2_HALF = 30'd1073676289;

  // floor(x / 6) = (x * INV6_MUL) >> INV6_SHIFT for x below 2^18
  localparam logic [21:0] INV6_MUL   = 22'd2796203;
  localparam int          INV6_SHIFT = 24;

  localparam int NUM_W      = 48;
  localparam int QUO_W      = 17;
  localparam int REM_W      = NUM_W - QUO_W;
  localparam int DEN_W      = 30;
  localparam int DIV_STAGES = QUO_W;
  localparam int LANES      = 3;

  typedef struct packed {
    logic        bwd;
    logic        half;
    logic        bad;
    logic        gray;
    logic [14:0] inten;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [DEN_W-1:0] den;
  } div_t;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic div_t div_step(input div_t a);
    div_t        r;
    logic [31:0] trial;
    logic [31:0] dext;
    r     = a;
    trial = {a.rem, a.low[QUO_W-1]};
    dext  = {2'b00, a.den};
    if (trial >= dext) begin
      r.rem = REM_W'(trial - dext);
      r.low = {a.low[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[REM_W-1:0];
      r.low = {a.low[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/rgb_ihs_pixel_converter_core.sv -----
// RGB <-> triangle-model IHS pixel converter core: decode, arithmetic front
// end, pipelined restoring divider and output register. Uses rgbihs_pkg.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------
//  cfg     | cfg_we cfg_index cfg_data                  | write on cfg_we
//  in      | in_first in_second in_third                | in_valid/in_ready
//  out     | out_first out_second out_third range_error | out_valid/out_ready
//
// One beat per cycle while the output is not stalled. The pipeline has 4 front
// stages, 17 divider stages (one quotient bit each) and 1 output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage in place. Reset clears config and valid bits.
`default_nettype none
module rgb_ihs_pixel_converter_core
  import rgbihs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_first,
  input  wire logic signed [15:0] in_second,
  input  wire logic signed [15:0] in_third,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [14:0]             out_first,
  output logic [14:0]             out_second,
  output logic [14:0]             out_third,
  output logic                    range_error
);

  logic reg_backward, reg_clamp, reg_half;
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_backward <= 1'b0;
      reg_clamp    <= 1'b0;
      reg_half     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKWARD: reg_backward <= cfg_data;
        CFG_CLAMP:    reg_clamp    <= cfg_data;
        CFG_HALF:     reg_half     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // ---------------- stage 1: sample decode ----------------
  logic [15:0] raw [LANES];
  logic [14:0] v_next [LANES];
  logic        bad_next;
  logic [14:0] s1_v [LANES];
  side_t       s1_side;
  logic        s1_vld;

  assign raw[0] = in_first;
  assign raw[1] = in_second;
  assign raw[2] = in_third;

  always_comb begin
    bad_next = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      if (reg_half) begin
        if (raw[j][15]) begin
          v_next[j] = '0;
          if (!reg_clamp) bad_next = 1'b1;
        end else begin
          v_next[j] = raw[j][14:0];
        end
      end else begin
        v_next[j] = {7'd0, raw[j][7:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= in_valid;
    if (en) begin
      s1_v    <= v_next;
      s1_side <= {reg_backward, reg_half, bad_next, 1'b0, 15'd0};
    end
  end

  // ---------------- stage 2: branch select, first products ----------------
  logic [14:0] fs1;
  logic [16:0] sum_c, m3_c, d_c, h3_c, fs_e, fs2x_e;
  logic [14:0] m_c, n_c, t_c;
  logic [1:0]  k_c, br_c;
  logic [18:0] kdn_c;
  logic        gray_c;

  logic [14:0] s2_i, s2_fs;
  logic [16:0] s2_sum, s2_d;
  logic [18:0] s2_kdn;
  logic [1:0]  s2_br;
  logic [29:0] s2_psfs, s2_pst;
  side_t       s2_side;
  logic        s2_vld;

  always_comb begin
    fs1    = s1_side.half ? FS_HALF : FS_BYTE;
    sum_c  = 17'(s1_v[0]) + 17'(s1_v[1]) + 17'(s1_v[2]);
    gray_c = (s1_v[0] == s1_v[1]) && (s1_v[1] == s1_v[2]);
    if (s1_v[2] <= s1_v[0] && s1_v[2] <= s1_v[1]) begin
      k_c = 2'd0; m_c = s1_v[2]; n_c = s1_v[1] - s1_v[2];
    end else if (s1_v[0] <= s1_v[1] && s1_v[0] <= s1_v[2]) begin
      k_c = 2'd1; m_c = s1_v[0]; n_c = s1_v[2] - s1_v[0];
    end else begin
      k_c = 2'd2; m_c = s1_v[1]; n_c = s1_v[0] - s1_v[1];
    end
    m3_c = {1'b0, m_c, 1'b0} + 17'(m_c);
    d_c  = sum_c - m3_c;
    case (k_c)
      2'd1:    kdn_c = 19'(d_c) + 19'(n_c);
      2'd2:    kdn_c = 19'({d_c, 1'b0}) + 19'(n_c);
      default: kdn_c = 19'(n_c);
    endcase
    // hue sector for the reverse direction
    h3_c   = {1'b0, s1_v[2], 1'b0} + 17'(s1_v[2]);
    fs_e   = 17'(fs1);
    fs2x_e = {1'b0, fs1, 1'b0};
    if (h3_c < fs_e) begin
      br_c = 2'd0; t_c = h3_c[14:0];
    end else if (h3_c < fs2x_e) begin
      br_c = 2'd1; t_c = 15'(h3_c - fs_e);
    end else begin
      br_c = 2'd2; t_c = 15'(h3_c - fs2x_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
    if (en) begin
      s2_i    <= s1_v[0];
      s2_fs   <= fs1;
      s2_sum  <= sum_c;
      s2_d    <= d_c;
      s2_kdn  <= kdn_c;
      s2_br   <= br_c;
      s2_psfs <= s1_v[1] * fs1;
      s2_pst  <= s1_v[1] * t_c;
      s2_side <= {s1_side.bwd, s1_side.half, s1_side.bad, gray_c, s1_side.inten};
    end
  end

  // ---------------- stage 3: forward products, reverse polynomials ----------------
  logic [29:0] fs2_c, lo_c;
  logic [31:0] pst3_c, up_c, dn_c;
  logic [32:0] dn_w;
  logic [17:0] ix_c;
  logic [39:0] iprod_c;
  logic [31:0] p_c [LANES];

  logic [31:0] s3_prod1;
  logic [33:0] s3_prod2;
  logic [16:0] s3_sum, s3_d;
  logic [14:0] s3_i;
  logic [29:0] s3_fs2;
  logic [31:0] s3_p [LANES];
  side_t       s3_side;
  logic        s3_vld;

  always_comb begin
    fs2_c   = s2_side.half ? FS2_HALF : FS2_BYTE;
    lo_c    = fs2_c - s2_psfs;
    pst3_c  = 32'({s2_pst, 1'b0}) + 32'(s2_pst);
    up_c    = 32'(lo_c) + pst3_c;
    dn_w    = 33'(fs2_c) + 33'({s2_psfs, 1'b0}) - 33'(pst3_c);
    dn_c    = dn_w[31:0];
    ix_c    = {s2_sum, 1'b0} + 18'd3;
    iprod_c = ix_c * INV6_MUL;
    case (s2_br)
      2'd0: begin
        p_c[0] = dn_c; p_c[1] = up_c; p_c[2] = 32'(lo_c);
      end
      2'd1: begin
        p_c[0] = 32'(lo_c); p_c[1] = dn_c; p_c[2] = up_c;
      end
      default: begin
        p_c[0] = up_c; p_c[1] = 32'(lo_c); p_c[2] = dn_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (en) s3_vld <= s2_vld;
    if (en) begin
      s3_prod1 <= s2_fs * s2_d;
      s3_prod2 <= s2_fs * s2_kdn;
      s3_sum   <= s2_sum;
      s3_d     <= s2_d;
      s3_i     <= s2_i;
      s3_fs2   <= fs2_c;
      s3_p     <= p_c;
      s3_side  <= {s2_side.bwd, s2_side.half, s2_side.bad, s2_side.gray,
                   iprod_c[INV6_SHIFT +: 15]};
    end
  end

  // ---------------- stage 4: numerators and denominators ----------------
  logic [NUM_W-1:0] num_c [LANES];
  logic [DEN_W-1:0] den_c [LANES];
  logic [NUM_W-1:0] f_num1, f_num2;

  always_comb begin
    f_num1 = NUM_W'({s3_prod1, 1'b0}) + NUM_W'(s3_sum);
    f_num2 = NUM_W'({s3_prod2, 1'b0}) + NUM_W'({s3_d, 1'b0}) + NUM_W'(s3_d);
    if (s3_side.bwd) begin
      for (int j = 0; j < LANES; j++) begin
        num_c[j] = NUM_W'(s3_i) * NUM_W'(s3_p[j]);
        den_c[j] = s3_fs2;
      end
    end else begin
      num_c[0] = '0;
      den_c[0] = DEN_W'(1);
      num_c[1] = f_num1;
      den_c[1] = DEN_W'({s3_sum, 1'b0});
      num_c[2] = f_num2;
      den_c[2] = DEN_W'({s3_d, 2'b00}) + DEN_W'({s3_d, 1'b0});
    end
  end

  // ---------------- stages 5..21: restoring divider, one quotient bit each ----------------
  div_t  dv [DIV_STAGES+1][LANES];
  side_t dv_side [DIV_STAGES+1];
  logic  dv_vld [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DIV_STAGES; j++) dv_vld[j] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= s3_vld;
      for (int j = 0; j < DIV_STAGES; j++) dv_vld[j+1] <= dv_vld[j];
    end
    if (en) begin
      dv_side[0] <= s3_side;
      // numerator splits into the partial remainder and the bits still to shift in
      for (int l = 0; l < LANES; l++) dv[0][l] <= {num_c[l], den_c[l]};
      for (int j = 0; j < DIV_STAGES; j++) begin
        dv_side[j+1] <= dv_side[j];
        for (int l = 0; l < LANES; l++) dv[j+1][l] <= div_step(dv[j][l]);
      end
    end
  end

  // ---------------- output register ----------------
  side_t       fin;
  logic [14:0] fin_fs;
  logic [14:0] res_c [LANES];

  always_comb begin
    fin    = dv_side[DIV_STAGES];
    fin_fs = fin.half ? FS_HALF : FS_BYTE;
    for (int l = 0; l < LANES; l++) begin
      if (dv[DIV_STAGES][l].low > QUO_W'(fin_fs)) res_c[l] = fin_fs;
      else res_c[l] = dv[DIV_STAGES][l].low[14:0];
    end
    if (fin.bad) begin
      for (int l = 0; l < LANES; l++) res_c[l] = '0;
    end else if (!fin.bwd) begin
      res_c[0] = fin.inten;
      if (fin.gray) begin
        res_c[1] = '0;
        res_c[2] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_vld[DIV_STAGES];
    if (en) begin
      out_first   <= res_c[0];
      out_second  <= res_c[1];
      out_third   <= res_c[2];
      range_error <= fin.bad;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rgbihs_checker.sv -----
// Port-level checks for the RGB/IHS converter core, bound to the core module.
// Sees only the core's ports; no package needed.
`default_nettype none
module rgbihs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] out_first,
  input wire logic [14:0] out_second,
  input wire logic [14:0] out_third,
  input wire logic        range_error
);

  // a flagged beat carries no samples
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> out_first == 15'd0 && out_second == 15'd0 &&
                                 out_third == 15'd0)
    else $error("range_error beat with nonzero samples");

  // hold an untaken beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_first) &&
                                $stable(out_second) && $stable(out_third))
    else $error("output beat changed while stalled");

  // backpressure only from a stalled output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rgb_ihs_pixel_converter_core rgbihs_checker u_rgbihs_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_first(out_first), .out_second(out_second),
  .out_third(out_third), .range_error(range_error)
);
`default_nettype wire
